// File: rtl/sha_mnc_pkg.sv
// Shared types, constants and SHA-256 helper functions for the midstate nonce checker.
// No dependencies; used by sha_mnc_round and sha256_midstate_nonce_check_top.
package sha_mnc_pkg;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_MID_AB   = 3'd0;
    localparam logic [2:0] REG_MID_CD   = 3'd1;
    localparam logic [2:0] REG_MID_EF   = 3'd2;
    localparam logic [2:0] REG_MID_GH   = 3'd3;
    localparam logic [2:0] REG_MSG_LEN  = 3'd4;
    localparam logic [2:0] REG_TARGET   = 3'd5;
    localparam logic [2:0] REG_PFX_BITS = 3'd6;

    localparam int          ADDR_W        = 6;
    localparam int          NUM_ROUNDS    = 64;
    localparam logic [31:0] PAD_WORD      = 32'h8000_0000;
    localparam logic [63:0] LEN_RESET     = 64'd64;
    localparam logic [6:0]  PFX_BITS_RST  = 7'd64;
    localparam logic [6:0]  PFX_BITS_MAX  = 7'd64;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // One pipeline word: nonce, working vars a..h (index 0 = a), schedule window
    typedef struct packed {
        logic [63:0]       nonce;
        logic [7:0][31:0]  hv;
        logic [15:0][31:0] w;
    } t_work;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: rtl/sha_mnc_round.sv
// One SHA-256 compression round plus one message-schedule step, registered.
// Depends on sha_mnc_pkg (t_work, round constants, sigma functions).
module sha_mnc_round #(
    parameter int ROUND = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sha_mnc_pkg::t_work i_work,
    output logic               o_valid,
    output sha_mnc_pkg::t_work o_work
);

    logic               r_valid;
    sha_mnc_pkg::t_work r_work;
    sha_mnc_pkg::t_work n_work;
    logic [31:0]        t1;
    logic [31:0]        t2;
    logic [31:0]        ch;
    logic [31:0]        maj;

    // Round function on a..h, consuming schedule word w[0]
    always_comb begin
        ch  = (i_work.hv[4] & i_work.hv[5]) ^ (~i_work.hv[4] & i_work.hv[6]);
        maj = (i_work.hv[0] & i_work.hv[1]) ^ (i_work.hv[0] & i_work.hv[2])
            ^ (i_work.hv[1] & i_work.hv[2]);
        t1  = i_work.hv[7] + sha_mnc_pkg::big_sigma1(i_work.hv[4]) + ch
            + sha_mnc_pkg::ROUND_K[ROUND] + i_work.w[0];
        t2  = sha_mnc_pkg::big_sigma0(i_work.hv[0]) + maj;

        n_work.nonce = i_work.nonce;
        n_work.hv[0] = t1 + t2;
        n_work.hv[1] = i_work.hv[0];
        n_work.hv[2] = i_work.hv[1];
        n_work.hv[3] = i_work.hv[2];
        n_work.hv[4] = i_work.hv[3] + t1;
        n_work.hv[5] = i_work.hv[4];
        n_work.hv[6] = i_work.hv[5];
        n_work.hv[7] = i_work.hv[6];

        // Slide the 16-word window and append the next expanded word
        for (int i = 0; i < 15; i++) begin
            n_work.w[i] = i_work.w[i + 1];
        end
        n_work.w[15] = sha_mnc_pkg::small_sigma1(i_work.w[14]) + i_work.w[9]
                     + sha_mnc_pkg::small_sigma0(i_work.w[1]) + i_work.w[0];
    end

    // Stage register; valid travels with the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// File: rtl/sha256_midstate_nonce_check_top.sv
// Top level of the SHA-256 midstate nonce checker: config registers, input stage,
// 64 round stages (sha_mnc_round), final add, prefix compare and output register.
// Depends on sha_mnc_pkg and sha_mnc_round.
//
// One nonce word is accepted per clock and one result word leaves per clock while the
// pipeline advances. The compression is fully unrolled into 64 round stages: a word
// passes an input register, 64 round registers and the output register that adds the
// midstate back and checks the digest prefix. The whole pipeline advances
// together; it stops only when a result waits on the output and the last round
// stage also holds a word, so bubbles ahead of a stalled result are filled.
// Config registers (APB, 8-byte stride) must be written while no word is in flight.
module sha256_midstate_nonce_check_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_nonce,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_nonce_out,
    output logic        o_match,
    output logic [63:0] o_digest_01,
    output logic [63:0] o_digest_23,
    output logic [63:0] o_digest_45,
    output logic [63:0] o_digest_67
);

    localparam int NR = sha_mnc_pkg::NUM_ROUNDS;

    // Config registers
    logic [63:0] r_mid_ab;
    logic [63:0] r_mid_cd;
    logic [63:0] r_mid_ef;
    logic [63:0] r_mid_gh;
    logic [63:0] r_msg_len;
    logic [63:0] r_target;
    logic [6:0]  r_pfx_bits;
    logic [63:0] r_pfx_mask;
    logic [63:0] n_pfx_mask;
    logic [6:0]  pfx_sat;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    logic [7:0][31:0] mid_words;

    // Pipeline
    logic                    adv;
    logic [NR:0]             stage_valid;
    sha_mnc_pkg::t_work      stage_work [0:NR];
    logic                    r_in_valid;
    sha_mnc_pkg::t_work      r_in_work;
    sha_mnc_pkg::t_work      n_in_work;

    // Output stage
    logic                    r_out_valid;
    logic [63:0]             r_out_nonce;
    logic                    r_out_match;
    logic [7:0][31:0]        r_out_digest;
    logic [7:0][31:0]        n_digest;
    logic                    n_match;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    // Config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_ab   <= '0;
            r_mid_cd   <= '0;
            r_mid_ef   <= '0;
            r_mid_gh   <= '0;
            r_msg_len  <= sha_mnc_pkg::LEN_RESET;
            r_target   <= '0;
            r_pfx_bits <= sha_mnc_pkg::PFX_BITS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                sha_mnc_pkg::REG_MID_AB:   r_mid_ab   <= pwdata;
                sha_mnc_pkg::REG_MID_CD:   r_mid_cd   <= pwdata;
                sha_mnc_pkg::REG_MID_EF:   r_mid_ef   <= pwdata;
                sha_mnc_pkg::REG_MID_GH:   r_mid_gh   <= pwdata;
                sha_mnc_pkg::REG_MSG_LEN:  r_msg_len  <= pwdata;
                sha_mnc_pkg::REG_TARGET:   r_target   <= pwdata;
                sha_mnc_pkg::REG_PFX_BITS: r_pfx_bits <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Config readback
    always_comb begin
        unique case (cfg_idx)
            sha_mnc_pkg::REG_MID_AB:   prdata = r_mid_ab;
            sha_mnc_pkg::REG_MID_CD:   prdata = r_mid_cd;
            sha_mnc_pkg::REG_MID_EF:   prdata = r_mid_ef;
            sha_mnc_pkg::REG_MID_GH:   prdata = r_mid_gh;
            sha_mnc_pkg::REG_MSG_LEN:  prdata = r_msg_len;
            sha_mnc_pkg::REG_TARGET:   prdata = r_target;
            sha_mnc_pkg::REG_PFX_BITS: prdata = {57'd0, r_pfx_bits};
            default:                   prdata = '0;
        endcase
    end

    // Prefix mask, saturated at 64 bits; a zero length compares nothing
    always_comb begin
        pfx_sat = (r_pfx_bits > sha_mnc_pkg::PFX_BITS_MAX) ? sha_mnc_pkg::PFX_BITS_MAX
                                                           : r_pfx_bits;
        if (pfx_sat == 7'd0) begin
            n_pfx_mask = '0;
        end else begin
            n_pfx_mask = {64{1'b1}} << (7'd64 - pfx_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfx_mask <= n_pfx_mask;
    end

    assign mid_words = {r_mid_gh[31:0], r_mid_gh[63:32], r_mid_ef[31:0], r_mid_ef[63:32],
                        r_mid_cd[31:0], r_mid_cd[63:32], r_mid_ab[31:0], r_mid_ab[63:32]};

    // Pipeline advances unless a result waits and the last round stage is full
    assign adv        = !r_out_valid || i_out_ready || !stage_valid[NR];
    assign o_in_ready = adv;

    // Build the final message block from the nonce
    always_comb begin
        n_in_work.nonce = i_nonce;
        n_in_work.hv    = mid_words;
        n_in_work.w     = '0;
        n_in_work.w[0]  = i_nonce[63:32];
        n_in_work.w[1]  = i_nonce[31:0];
        n_in_work.w[2]  = sha_mnc_pkg::PAD_WORD;
        n_in_work.w[14] = r_msg_len[63:32];
        n_in_work.w[15] = r_msg_len[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_work <= n_in_work;
        end
    end

    assign stage_valid[0] = r_in_valid;
    assign stage_work[0]  = r_in_work;

    // 64 round stages
    for (genvar g = 0; g < NR; g++) begin : g_round
        sha_mnc_round #(
            .ROUND (g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (stage_valid[g]),
            .i_work  (stage_work[g]),
            .o_valid (stage_valid[g + 1]),
            .o_work  (stage_work[g + 1])
        );
    end

    // Feed-forward add and prefix check
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_digest[i] = stage_work[NR].hv[i] + mid_words[i];
        end
        n_match = ((({n_digest[0], n_digest[1]}) ^ r_target) & r_pfx_mask) == 64'd0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && stage_valid[NR]) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && stage_valid[NR]) begin
            r_out_nonce  <= stage_work[NR].nonce;
            r_out_match  <= n_match;
            r_out_digest <= n_digest;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_nonce_out = r_out_nonce;
    assign o_match     = r_out_match;
    assign o_digest_01 = {r_out_digest[0], r_out_digest[1]};
    assign o_digest_23 = {r_out_digest[2], r_out_digest[3]};
    assign o_digest_45 = {r_out_digest[4], r_out_digest[5]};
    assign o_digest_67 = {r_out_digest[6], r_out_digest[7]};

endmodule

// File: rtl/sha_mnc_checker.sv
// Port-level checker for sha256_midstate_nonce_check_top, bound to it below.
// No package dependencies.
module sha_mnc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_nonce_out,
    input logic [63:0] o_digest_01,
    input logic        o_match
);

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Config port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

    // Input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output free");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_nonce_out)
            && $stable(o_digest_01) && $stable(o_match))
        else $error("stalled result changed");

endmodule

bind sha256_midstate_nonce_check_top sha_mnc_checker u_sha_mnc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .pready      (pready),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_nonce_out (o_nonce_out),
    .o_digest_01 (o_digest_01),
    .o_match     (o_match)
);
